@@ rtl/mrpt_pkg.sv @@
// ----------------------------------------------------------------------------
// mrpt_pkg: shared constants for the primality tester
// witness base table used by the sequencer
// ----------------------------------------------------------------------------
package mrpt_pkg;

   localparam int BASE_COUNT = 7;

   function automatic logic [31:0] witness_base(input logic [2:0] idx);
      logic [31:0] b;
      unique case (idx)
         3'd0: b = 32'd2;
         3'd1: b = 32'd325;
         3'd2: b = 32'd9375;
         3'd3: b = 32'd28178;
         3'd4: b = 32'd450775;
         3'd5: b = 32'd9780504;
         3'd6: b = 32'd1795265022;
         default: b = 32'd0;
      endcase
      return b;
   endfunction

endpackage

@@ rtl/miller_rabin_prime_test_64.sv @@
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64: deterministic primality test of one word
// square-and-multiply over a shared bit-serial modular multiplier
// ----------------------------------------------------------------------------
//
//  channel | direction | ports
//  --------+-----------+--------------------------------------
//  request | in        | req_valid, req_ready, req_candidate
//  result  | out       | rsp_valid, rsp_ready, rsp_prime_flag
//
// one candidate at a time; about 2*WORD_BITS modular multiplies per base
// time is set by the single shift-add-reduce multiplier and the base loop
// base reduction mod n uses a restoring divide over the 32 base bits, one bit
// per cycle
// synchronous reset returns to idle; a held result stalls the next request
// until the transfer on the result side completes
module miller_rabin_prime_test_64 #(
   parameter int WORD_BITS = 64,
   parameter int NUM_BASES = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_candidate,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_prime_flag
);

   localparam int W         = WORD_BITS;
   localparam int BASE_BITS = 32;
   localparam int CW        = $clog2(((W > BASE_BITS) ? W : BASE_BITS) + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SPLIT, S_BASE, S_RED, S_POW, S_MUL, S_CHK, S_SQ, S_DONE
   } state_type;

   // which multiply the unit is running
   typedef enum logic [1:0] {M_ACC, M_BSQ, M_XSQ} mop_type;

   state_type      state_ff;
   mop_type        mop_ff;
   logic [W-1:0]   n_ff, d_ff, e_ff, b_ff, acc_ff;
   logic [CW-1:0]  s_ff, j_ff;
   logic [2:0]     k_ff;
   // shared multiplier / divider
   logic [W-1:0]   ma_ff, mb_ff, r_ff;
   logic [BASE_BITS-1:0] bsh_ff;
   logic [CW-1:0]  cnt_ff;
   logic           flag_ff;

   logic [W:0]     dbl, sum1;
   logic [W-1:0]   rd, radd, nm1;
   logic           mbit;

   assign nm1    = n_ff - W'(1);
   assign mbit   = mb_ff[W-1];

   // one multiplier step: r = 2r (+a) mod n
   always_comb begin
      dbl  = {r_ff, 1'b0};
      rd   = (dbl >= {1'b0, n_ff}) ? W'(dbl - {1'b0, n_ff}) : dbl[W-1:0];
      sum1 = {1'b0, rd} + {1'b0, ma_ff};
      radd = (sum1 >= {1'b0, n_ff}) ? W'(sum1 - {1'b0, n_ff}) : sum1[W-1:0];
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = (state_ff == S_DONE);
   assign rsp_prime_flag = flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         flag_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  n_ff  <= req_candidate[W-1:0];
                  d_ff  <= req_candidate[W-1:0] - W'(1);
                  s_ff  <= '0;
                  k_ff  <= '0;
                  if (req_candidate[W-1:0] < W'(2)) begin
                     flag_ff  <= 1'b0;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_SPLIT;
                  end
               end
            end
            S_SPLIT: begin
               if (!d_ff[0]) begin
                  d_ff <= d_ff >> 1;
                  s_ff <= s_ff + CW'(1);
               end else begin
                  state_ff <= S_BASE;
               end
            end
            S_BASE: begin
               if (32'(k_ff) >= 32'(NUM_BASES)) begin
                  flag_ff  <= 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  // base mod n: shift base bits in msb first
                  r_ff     <= '0;
                  bsh_ff   <= mrpt_pkg::witness_base(k_ff);
                  cnt_ff   <= CW'(BASE_BITS);
                  state_ff <= S_RED;
               end
            end
            S_RED: begin
               if (cnt_ff == '0) begin
                  if (r_ff == '0) begin
                     k_ff     <= k_ff + 3'd1;
                     state_ff <= S_BASE;
                  end else begin
                     b_ff     <= r_ff;
                     acc_ff   <= W'(1);
                     e_ff     <= d_ff;
                     state_ff <= S_POW;
                  end
               end else begin
                  // remainder stays below n, so one subtract suffices
                  r_ff   <= (({r_ff, bsh_ff[BASE_BITS-1]}) >= {1'b0, n_ff})
                            ? W'({r_ff, bsh_ff[BASE_BITS-1]} - {1'b0, n_ff})
                            : {r_ff[W-2:0], bsh_ff[BASE_BITS-1]};
                  bsh_ff <= bsh_ff << 1;
                  cnt_ff <= cnt_ff - CW'(1);
               end
            end
            S_POW: begin
               r_ff   <= '0;
               cnt_ff <= CW'(W);
               if (e_ff == '0) begin
                  j_ff <= '0;
                  if (acc_ff == W'(1)) begin
                     k_ff     <= k_ff + 3'd1;
                     state_ff <= S_BASE;
                  end else begin
                     state_ff <= S_CHK;
                  end
               end else if (e_ff[0]) begin
                  ma_ff    <= acc_ff;
                  mb_ff    <= b_ff;
                  mop_ff   <= M_ACC;
                  state_ff <= S_MUL;
               end else begin
                  ma_ff    <= b_ff;
                  mb_ff    <= b_ff;
                  mop_ff   <= M_BSQ;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               if (cnt_ff == '0) begin
                  unique case (mop_ff)
                     M_ACC: begin
                        acc_ff   <= r_ff;
                        r_ff     <= '0;
                        ma_ff    <= b_ff;
                        mb_ff    <= b_ff;
                        cnt_ff   <= CW'(W);
                        mop_ff   <= M_BSQ;
                     end
                     M_BSQ: begin
                        b_ff     <= r_ff;
                        e_ff     <= e_ff >> 1;
                        state_ff <= S_POW;
                     end
                     default: begin
                        acc_ff   <= r_ff;
                        j_ff     <= j_ff + CW'(1);
                        state_ff <= S_CHK;
                     end
                  endcase
               end else begin
                  r_ff   <= mbit ? radd : rd;
                  mb_ff  <= mb_ff << 1;
                  cnt_ff <= cnt_ff - CW'(1);
               end
            end
            S_CHK: begin
               if (j_ff >= s_ff) begin
                  flag_ff  <= 1'b0;
                  state_ff <= S_DONE;
               end else if (acc_ff == nm1) begin
                  k_ff     <= k_ff + 3'd1;
                  state_ff <= S_BASE;
               end else begin
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               r_ff     <= '0;
               ma_ff    <= acc_ff;
               mb_ff    <= acc_ff;
               cnt_ff   <= CW'(W);
               mop_ff   <= M_XSQ;
               state_ff <= S_MUL;
            end
            S_DONE: begin
               if (rsp_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   // the running remainder never reaches the modulus
   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL || state_ff == S_RED) |-> r_ff < n_ff)
      else $error("remainder not reduced");
   // a candidate below two finishes at once as composite
   a_small: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_candidate[W-1:0] < W'(2))
      |=> (rsp_valid && !rsp_prime_flag))
      else $error("small candidate not rejected");
   // squaring count never passes s
   a_jbound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SQ |-> j_ff < s_ff)
      else $error("square count overrun");
`endif

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: primality tester regression
// feeds 64-bit candidates through the request channel and checks every
// prime/composite verdict against a local square-and-multiply predictor
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CLK_HALF    = 6;
   localparam int WATCHDOG    = 400000;
   localparam int LONG_HOLD   = 80000;    // longer than one full test
   localparam int TAIL_CYCLES = 50;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_candidate;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_prime_flag;

   // verdicts waiting for their result transfer, oldest first
   bit          verdict_q[$];
   int          error_count;
   int          quiet_cycles;
   bit          idle_enable;
   bit          long_hold_req;

   miller_rabin_prime_test_64 DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_candidate (req_candidate),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_prime_flag(rsp_prime_flag)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // predictor: modular arithmetic done on a 128-bit product
   // ---------------------------------------------------------------------
   function automatic logic [63:0] mulmod64(logic [63:0] a, logic [63:0] b,
                                            logic [63:0] m);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return 64'(prod % {64'd0, m});
   endfunction

   function automatic logic [63:0] powmod64(logic [63:0] b, logic [63:0] e,
                                            logic [63:0] m);
      logic [63:0] acc;
      acc = 64'd1 % m;
      while (e != 64'd0) begin
         if (e[0])
            acc = mulmod64(acc, b, m);
         b = mulmod64(b, b, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic bit predict_prime(logic [63:0] n);
      logic [63:0] witnesses [7];
      logic [63:0] odd_part;
      logic [63:0] x;
      logic [63:0] base_red;
      int          twos;
      bit          passed;
      witnesses = '{64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775,
                    64'd9780504, 64'd1795265022};
      // zero and one are never prime
      if (n < 64'd2)
         return 1'b0;
      odd_part = n - 64'd1;
      twos = 0;
      while (!odd_part[0] && odd_part != 64'd0) begin
         odd_part = odd_part >> 1;
         twos++;
      end
      for (int k = 0; k < mrpt_pkg::BASE_COUNT; k++) begin
         base_red = witnesses[k] % n;
         // base that is a multiple of n tells nothing
         if (base_red == 64'd0)
            continue;
         x = powmod64(base_red, odd_part, n);
         if (x == 64'd1)
            continue;
         passed = 1'b0;
         for (int j = 0; j < twos; j++) begin
            if (x == n - 64'd1) begin
               passed = 1'b1;
               break;
            end
            x = mulmod64(x, x, n);
         end
         if (!passed)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // request side: one candidate per call, valid held until the transfer
   // ---------------------------------------------------------------------
   task automatic send_candidate(logic [63:0] n);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_candidate = n;
      // sampled at the rising edge, before the block updates its flops
      do @(posedge clock); while (!req_ready);
      verdict_q.push_back(predict_prime(n));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_all_verdicts();
      while (verdict_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      $display("mismatch @%0t: %s expected %0d got %0d", $time, what, want, got);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // result side: ready with random stall bursts, plus one long hold-off
   // ---------------------------------------------------------------------
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_req = 1'b0;
         end
         if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 7) - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // checker: each result transfer against the oldest verdict
   always @(posedge clock) begin
      bit want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_q.size() == 0) begin
            report_mismatch("unexpected result, prime_flag", 64'd0,
                            64'(rsp_prime_flag));
         end else begin
            want = verdict_q.pop_front();
            if (rsp_prime_flag !== want)
               report_mismatch("prime_flag", 64'(want), 64'(rsp_prime_flag));
         end
      end
   end

   // watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_directed();
      logic [63:0] picks [$];
      picks = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9, 64'd25,
                64'd561,                      // carmichael number
                64'd2047,                     // strong pseudoprime to base 2
                64'd3215031751,               // fools bases 2,3,5,7
                64'd325, 64'd1795265022,      // bases themselves, composite
                64'd4294967291,               // largest 32-bit prime
                64'd4294967291 * 64'd4294967291,
                64'h8000_0000_0000_0000,      // even, top bit only
                64'd2305843009213693951,      // mersenne prime 2^61-1
                64'd18446744073709551557,     // largest 64-bit prime
                64'hFFFF_FFFF_FFFF_FFFF,
                64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB};
      foreach (picks[i])
         send_candidate(picks[i]);
   endtask

   task automatic test_random_mix(int count);
      logic [63:0] n;
      logic [63:0] p;
      logic [63:0] q;
      repeat (count) begin
         case ($urandom_range(0, 3))
            0: n = {$urandom, $urandom};
            1: n = {1'b1, 31'($urandom), 31'($urandom), 1'b1};
            2: n = 64'($urandom_range(0, 1 << 20));
            default: begin
               // odd semiprime-like product, hard composite
               p = {32'd0, $urandom | 32'd1};
               q = {32'd0, $urandom | 32'd1};
               n = p * q;
            end
         endcase
         send_candidate(n);
      end
   endtask

   // block holds its result while the sender keeps offering
   task automatic test_backpressure();
      long_hold_req = 1'b1;
      test_random_mix(3);
      wait_all_verdicts();
   endtask

   // sender stops until every verdict is back, then resumes
   task automatic test_drain_pause();
      test_random_mix(4);
      wait_all_verdicts();
      test_random_mix(4);
   endtask

   task automatic test_no_idle();
      idle_enable = 1'b0;
      test_random_mix(12);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_candidate = 64'd0;
      error_count   = 0;
      quiet_cycles  = 0;
      idle_enable   = 1'b1;
      long_hold_req = 1'b0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_mix(55);
      test_backpressure();
      test_drain_pause();
      test_no_idle();

      wait_all_verdicts();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
